/* rtl/strict_priority_multi_fifo_unit_macros.svh */
// Assertion helpers; expect clk and rst_n in scope
`ifndef STRICT_PRIORITY_MULTI_FIFO_UNIT_MACROS_SVH
`define STRICT_PRIORITY_MULTI_FIFO_UNIT_MACROS_SVH

// Same-cycle implication
`define SPMF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spmf assertion failed");

// Next-cycle implication
`define SPMF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spmf assertion failed");

`endif

/* rtl/spmf_pkg.sv */
`default_nettype none
package spmf_pkg;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 4;
  localparam int LEVEL_W = 3;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Result info handed from control to the result register
  typedef struct packed {
    status_t              status;
    logic [LEVEL_W-1:0]   level;
    logic                 all_empty;
    logic                 is_read;
  } res_t;

endpackage
`default_nettype wire

/* rtl/spmf_if.sv */
`default_nettype none
interface spmf_in_if;
  logic                                  valid;
  logic                                  ready;
  spmf_pkg::mode_t                       mode;
  logic signed [spmf_pkg::VALUE_W-1:0]   value;
  logic signed [spmf_pkg::PRIO_W-1:0]    priority_req;

  modport source (output valid, mode, value, priority_req, input ready);
  modport sink (input valid, mode, value, priority_req, output ready);
endinterface

interface spmf_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [spmf_pkg::VALUE_W-1:0]   value_out;
  spmf_pkg::status_t                     status;
  logic [spmf_pkg::LEVEL_W-1:0]          level;
  logic                                  all_empty;

  modport source (output valid, value_out, status, level, all_empty, input ready);
  modport sink (input valid, value_out, status, level, all_empty, output ready);
endinterface
`default_nettype wire

/* rtl/strict_priority_multi_fifo_unit.sv */
// Channel | Dir | Fields                                  | Handshake
// in_chan | in  | mode, value, priority_req                | valid/ready
// out_chan| out | value_out, status, level, all_empty      | valid/ready
//
// One item per cycle sustained while the output is not stalled; each item passes
// through the input register, then the result register alongside the entry RAM read port.
// The queue decision is a priority encoder over the per-level counts.
// Reset (rst_n low, synchronous) empties every level; the entry RAM keeps
// its contents and needs no clearing pass.
// A stalled output holds the result register and the RAM read data; the input
// register keeps taking items until both stages are full.
`default_nettype none
module strict_priority_multi_fifo_unit #(
  parameter int LEVELS      = 6,
  parameter int LEVEL_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input wire logic  clk,
  input wire logic  rst_n,
  spmf_in_if.sink   in_chan,
  spmf_out_if.source out_chan
);
  import spmf_pkg::*;

  localparam int AW = $clog2(LEVELS * LEVEL_DEPTH);

  logic                       s1_valid_r;
  mode_t                      s1_mode_r;
  logic signed [VALUE_W-1:0]  s1_value_r;
  logic signed [PRIO_W-1:0]   s1_prio_r;
  logic                       s2_valid_r;
  res_t                       s2_res_r;

  logic                       s1_adv;
  logic                       op_go;
  logic                       mem_we;
  logic                       mem_re;
  logic [AW-1:0]              mem_addr;
  logic [DATA_WIDTH-1:0]      mem_rdata;
  res_t                       res;

  assign s1_adv        = !s2_valid_r || out_chan.ready;
  assign op_go         = s1_valid_r && s1_adv;
  assign in_chan.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (s1_adv) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_mode_r  <= in_chan.mode;
      s1_value_r <= in_chan.value;
      s1_prio_r  <= in_chan.priority_req;
    end
    if (op_go) begin
      s2_res_r <= res;
    end
  end

  spmf_ctrl #(
    .LEVELS      (LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .op_go        (op_go),
    .mode         (s1_mode_r),
    .priority_req (s1_prio_r),
    .mem_we       (mem_we),
    .mem_re       (mem_re),
    .mem_addr     (mem_addr),
    .res          (res)
  );

  // Read data lands with the result register and holds while stalled
  spmf_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (LEVELS * LEVEL_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (DATA_WIDTH'($unsigned(s1_value_r))),
    .re    (mem_re),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  assign out_chan.valid     = s2_valid_r;
  assign out_chan.value_out = s2_res_r.is_read ? $signed(VALUE_W'(mem_rdata)) : '0;
  assign out_chan.status    = s2_res_r.status;
  assign out_chan.level     = s2_res_r.level;
  assign out_chan.all_empty = s2_res_r.all_empty;

endmodule
`default_nettype wire

/* rtl/spmf_ram.sv */
`default_nettype none
module spmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 96
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/spmf_ctrl.sv */
`default_nettype none
`include "strict_priority_multi_fifo_unit_macros.svh"
module spmf_ctrl #(
  parameter int LEVELS      = 6,
  parameter int LEVEL_DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      op_go,
  input  wire spmf_pkg::mode_t                           mode,
  input  wire logic signed [spmf_pkg::PRIO_W-1:0]        priority_req,
  output      logic                                      mem_we,
  output      logic                                      mem_re,
  output      logic [$clog2(LEVELS*LEVEL_DEPTH)-1:0]     mem_addr,
  output      spmf_pkg::res_t                            res
);
  import spmf_pkg::*;

  localparam int LW = $clog2(LEVELS);
  localparam int PW = $clog2(LEVEL_DEPTH);
  localparam int CW = $clog2(LEVEL_DEPTH + 1);
  localparam int AW = $clog2(LEVELS * LEVEL_DEPTH);

  logic [PW-1:0] head_r   [LEVELS];
  logic [PW-1:0] head_nxt [LEVELS];
  logic [PW-1:0] tail_r   [LEVELS];
  logic [PW-1:0] tail_nxt [LEVELS];
  logic [CW-1:0] cnt_r    [LEVELS];
  logic [CW-1:0] cnt_nxt  [LEVELS];

  logic [LEVELS-1:0] nonempty;
  logic [LW-1:0]     ins_lvl;
  logic [LW-1:0]     srv_lvl;
  logic              found;
  logic              full;
  logic              is_ins;
  logic              do_wr;
  logic              do_rd;
  logic              empty_after;

  function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(LEVEL_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  // Clamp the requested level
  always_comb begin
    if (priority_req[PRIO_W-1]) begin
      ins_lvl = '0;
    end else if (32'(priority_req[PRIO_W-2:0]) > 32'(LEVELS - 1)) begin
      ins_lvl = LW'(LEVELS - 1);
    end else begin
      ins_lvl = LW'(priority_req[PRIO_W-2:0]);
    end
  end

  // Lowest-numbered non-empty level wins
  always_comb begin
    srv_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      nonempty[i] = (cnt_r[i] != '0);
    end
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        srv_lvl = LW'(i);
      end
    end
  end

  assign found  = |nonempty;
  assign full   = (cnt_r[ins_lvl] == CW'(LEVEL_DEPTH));
  assign is_ins = (mode == MODE_INSERT);
  assign do_wr  = op_go && is_ins && !full;
  assign do_rd  = op_go && !is_ins && found;

  assign mem_we   = do_wr;
  assign mem_re   = do_rd;
  assign mem_addr = do_wr ? AW'(ins_lvl) * AW'(LEVEL_DEPTH) + AW'(tail_r[ins_lvl])
                          : AW'(srv_lvl) * AW'(LEVEL_DEPTH) + AW'(head_r[srv_lvl]);

  always_comb begin
    empty_after = 1'b1;
    for (int i = 0; i < LEVELS; i++) begin
      head_nxt[i] = head_r[i];
      tail_nxt[i] = tail_r[i];
      cnt_nxt[i]  = cnt_r[i];
      if (do_wr && ins_lvl == LW'(i)) begin
        tail_nxt[i] = next_pos(tail_r[i]);
        cnt_nxt[i]  = cnt_r[i] + CW'(1);
      end
      if (do_rd && srv_lvl == LW'(i)) begin
        head_nxt[i] = next_pos(head_r[i]);
        cnt_nxt[i]  = cnt_r[i] - CW'(1);
      end
      if (cnt_nxt[i] != '0) begin
        empty_after = 1'b0;
      end
    end
  end

  always_comb begin
    res.all_empty = empty_after;
    res.is_read   = do_rd;
    if (is_ins) begin
      res.status = full ? ST_FULL : ST_OK;
      res.level  = LEVEL_W'(ins_lvl);
    end else begin
      res.status = found ? ST_OK : ST_EMPTY;
      res.level  = found ? LEVEL_W'(srv_lvl) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= head_nxt[i];
        tail_r[i] <= tail_nxt[i];
        cnt_r[i]  <= cnt_nxt[i];
      end
    end
  end

  `SPMF_ASSERT_NOW(a_no_rw_clash, 1'b1, !(mem_we && mem_re))
  `SPMF_ASSERT_NOW(a_remove_serves, op_go && mode == MODE_REMOVE && nonempty != '0, mem_re)
  `SPMF_ASSERT_NEXT(a_write_fills, mem_we, nonempty != '0)

endmodule
`default_nettype wire

/* tb/sv/strict_priority_multi_fifo_unit_tb.sv */
`default_nettype none
module strict_priority_multi_fifo_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spmf_pkg::*;

  localparam int NUM_LEVELS = 6;
  localparam int SLOTS = 16;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int RUN_LIMIT = 100000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_out;
    status_t                   status;
    logic [LEVEL_W-1:0]        level;
    logic                      all_empty;
  } pq_result_t;

  logic clk;
  logic rst_n;

  spmf_in_if  in_bus ();
  spmf_out_if out_bus ();

  strict_priority_multi_fifo_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  // Queue shadow: per-level ring buffers with read/write positions and fill counts
  logic [VALUE_W-1:0] slot_data [NUM_LEVELS][SLOTS];
  int unsigned rd_pos [NUM_LEVELS] = '{default: 0};
  int unsigned wr_pos [NUM_LEVELS] = '{default: 0};
  int unsigned fill [NUM_LEVELS] = '{default: 0};

  pq_result_t expected_results [$];
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [LEVEL_W-1:0] clamp_level(logic signed [PRIO_W-1:0] p);
    if (p < 0) return '0;
    if (p > NUM_LEVELS - 1) return LEVEL_W'(NUM_LEVELS - 1);
    return p[LEVEL_W-1:0];
  endfunction

  // Pick a requested priority that lands on lv, using the clamp aliases at both ends
  function automatic logic signed [PRIO_W-1:0] pick_priority(int lv);
    int p;
    if (lv == 0) p = -int'($urandom_range(8));
    else if (lv == NUM_LEVELS - 1) p = lv + int'($urandom_range(2));
    else p = lv;
    return p[PRIO_W-1:0];
  endfunction

  function automatic pq_result_t apply_queue_op(mode_t m, logic signed [VALUE_W-1:0] v,
                                                logic signed [PRIO_W-1:0] p);
    pq_result_t r;
    int lv;
    r = '0;
    r.status = ST_OK;
    if (m == MODE_INSERT) begin
      lv = clamp_level(p);
      r.level = LEVEL_W'(lv);
      if (fill[lv] >= SLOTS) begin
        r.status = ST_FULL;
      end else begin
        slot_data[lv][wr_pos[lv]] = v;
        wr_pos[lv] = (wr_pos[lv] + 1) % SLOTS;
        fill[lv]++;
      end
    end else begin
      r.status = ST_EMPTY;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        if (r.status == ST_EMPTY && fill[i] != 0) begin
          r.status = ST_OK;
          r.level = LEVEL_W'(i);
          r.value_out = slot_data[i][rd_pos[i]];
          rd_pos[i] = (rd_pos[i] + 1) % SLOTS;
          fill[i]--;
        end
      end
    end
    r.all_empty = 1'b1;
    foreach (fill[i]) if (fill[i] != 0) r.all_empty = 1'b0;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_op(mode_t m, logic signed [VALUE_W-1:0] v,
                         logic signed [PRIO_W-1:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.mode = m;
    in_bus.value = v;
    in_bus.priority_req = p;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    expected_results.push_back(apply_queue_op(m, v, p));
    items_sent++;
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  task automatic wait_for_results();
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed_extremes();
    send_op(MODE_REMOVE, 32'sd0, 4'sd0);
    send_op(MODE_INSERT, 32'sh7fff_ffff, 4'sd7);
    send_op(MODE_INSERT, 32'sh8000_0000, -4'sd8);
    send_op(MODE_INSERT, 32'sd0, 4'sd5);
    send_op(MODE_INSERT, -32'sd1, 4'sd6);
    send_op(MODE_INSERT, 32'sd1, -4'sd1);
    send_op(MODE_INSERT, 32'sh5555_5555, 4'sd3);
    send_op(MODE_INSERT, 32'shaaaa_aaaa, 4'sd1);
    send_op(MODE_INSERT, 32'sd2, 4'sd2);
    send_op(MODE_INSERT, 32'sd4, 4'sd4);
    // drain in strict priority order, then one more on the empty queue
    repeat (10) send_op(MODE_REMOVE, $urandom, 4'($urandom_range(15)));
  endtask

  task automatic test_level_overflow();
    int lv;
    int n;
    lv = $urandom_range(NUM_LEVELS - 1);
    n = SLOTS + $urandom_range(3);
    repeat (n) send_op(MODE_INSERT, $urandom, pick_priority(lv));
    repeat ($urandom_range(20)) send_op(MODE_REMOVE, $urandom, 4'($urandom_range(15)));
  endtask

  task automatic test_mixed_ops(int insert_pct);
    mode_t m;
    repeat (8 + $urandom_range(16)) begin
      m = ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
      send_op(m, $urandom, 4'($urandom_range(15)));
    end
  endtask

  task automatic test_drain_queue();
    int total;
    total = 0;
    foreach (fill[i]) total += fill[i];
    repeat (total + $urandom_range(1, 2))
      send_op(MODE_REMOVE, $urandom, 4'($urandom_range(15)));
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct);
    int unsigned start;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < ITEMS_PER_PHASE) begin
      case ($urandom_range(9))
        0, 1: test_level_overflow();
        2, 3, 4, 5: test_mixed_ops(55);
        6, 7: test_drain_queue();
        default: test_mixed_ops(30);
      endcase
    end
    wait_for_results();
  endtask

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    pq_result_t want;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %0d status %0d level %0d all_empty %0d",
                   out_bus.value_out, out_bus.status, out_bus.level, out_bus.all_empty);
      end else begin
        want = expected_results.pop_front();
        if (out_bus.value_out !== want.value_out || out_bus.status !== want.status ||
            out_bus.level !== want.level || out_bus.all_empty !== want.all_empty) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %0d status %0d level %0d all_empty %0d, %s",
                     want.value_out, want.status, want.level, want.all_empty,
                     $sformatf("got value %0d status %0d level %0d all_empty %0d",
                               out_bus.value_out, out_bus.status, out_bus.level,
                               out_bus.all_empty));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.mode = MODE_INSERT;
    in_bus.value = '0;
    in_bus.priority_req = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_directed_extremes();
    // hold the sender until every result is back
    wait_for_results();
    test_random_phase(0, 0);
    test_random_phase(74, 0);
    test_random_phase(0, 74);
    test_random_phase(34, 34);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
